// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the CRC engine.
// Depends on nothing; simulation builds see the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== hdl/cce_pkg.sv =====
// Shared types and constants of the configurable CRC engine.
// No dependencies.
package cce_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_POLY        = 3'd0,
    REG_ORDER       = 3'd1,
    REG_INIT        = 3'd2,
    REG_XOR_OUT     = 3'd3,
    REG_REFLECT_IN  = 3'd4,
    REG_REFLECT_OUT = 3'd5
  } cce_reg_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ORDER_W    = 6;

  localparam logic [31:0]        POLY_RESET  = 32'h04C1_1DB7;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd32;
  localparam logic [31:0]        INIT_RESET  = 32'hFFFF_FFFF;
  localparam logic [31:0]        XOR_RESET   = 32'hFFFF_FFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef struct packed {
    logic [31:0]        poly_value;
    logic [ORDER_W-1:0] crc_order;
    logic [31:0]        init_value;
    logic [31:0]        xor_out;
    logic               reflect_in;
    logic               reflect_out;
  } cce_cfg_t;

  // classified item: byte already in MSB-first feed order
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cce_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } cce_qstat_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

// ===== hdl/cce_front.sv =====
// Input side of the CRC engine: registers each byte and applies input reflection.
// Depends on cce_pkg.
module cce_front (
  input  logic                clk,
  input  logic                rst,
  input  cce_pkg::cce_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  input  logic                q_full,
  output logic                push,
  output cce_pkg::cce_item_t  push_item
);

  logic               item_valid;
  cce_pkg::cce_item_t item;

  assign push      = item_valid && !q_full;
  assign in_ready  = !item_valid || !q_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data <= cfg.reflect_in ? cce_pkg::rev8(in_data) : in_data;
      item.last <= in_last;
    end
  end

endmodule

// ===== hdl/cce_queue.sv =====
// Short FIFO between the front and back parts of the CRC engine.
// Depends on cce_pkg.
module cce_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cce_pkg::cce_item_t  push_item,
  input  logic                pop,
  output cce_pkg::cce_item_t  head,
  output cce_pkg::cce_qstat_t stat
);

  localparam int PW = cce_pkg::QUEUE_PTR_W;

  cce_pkg::cce_item_t mem [cce_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == (PW+1)'(cce_pkg::QUEUE_DEPTH));
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hdl/cce_back.sv =====
// CRC update core: eight MSB-first shift/XOR steps per byte, message framing.
// Depends on cce_pkg.
module cce_back #(
  parameter int MAX_ORDER = 32,
  parameter int OW        = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cce_pkg::cce_cfg_t    cfg,
  input  cce_pkg::cce_item_t   head,
  input  cce_pkg::cce_qstat_t  qstat,
  output logic                 pop,
  input  logic                 fin_take,
  output logic                 fin_valid,
  output logic [MAX_ORDER-1:0] fin_crc,
  output logic [OW-1:0]        ord_n,
  output logic [MAX_ORDER-1:0] ord_mask
);

  localparam int CW = (OW > cce_pkg::ORDER_W) ? OW : cce_pkg::ORDER_W;

  logic [MAX_ORDER-1:0] running_crc;
  logic                 mid_message;
  logic [CW-1:0]        ord_ext;
  logic [MAX_ORDER-1:0] top_bit;
  logic [MAX_ORDER-1:0] poly_m;
  logic [MAX_ORDER-1:0] crc_start;
  logic [MAX_ORDER-1:0] crc_next;
  logic                 fb;

  // order zero runs as order one, large orders saturate
  always_comb begin
    ord_ext = CW'(cfg.crc_order);
    if (ord_ext == '0) begin
      ord_n = OW'(1);
    end else if (ord_ext > CW'(MAX_ORDER)) begin
      ord_n = OW'(MAX_ORDER);
    end else begin
      ord_n = OW'(ord_ext);
    end
  end

  assign ord_mask  = {MAX_ORDER{1'b1}} >> (OW'(MAX_ORDER) - ord_n);
  assign top_bit   = MAX_ORDER'(1) << (ord_n - OW'(1));
  assign poly_m    = MAX_ORDER'(cfg.poly_value) & ord_mask;
  assign crc_start = mid_message ? (running_crc & ord_mask)
                                 : (MAX_ORDER'(cfg.init_value) & ord_mask);

  always_comb begin
    crc_next = crc_start;
    fb       = 1'b0;
    for (int k = 0; k < 8; k++) begin
      fb       = (|(crc_next & top_bit)) ^ head.data[7-k];
      crc_next = (crc_next << 1) & ord_mask;
      if (fb) begin
        crc_next = crc_next ^ poly_m;
      end
    end
  end

  // a last byte needs the result register free (or emptying this cycle)
  assign pop = qstat.valid && (!head.last || !fin_valid || fin_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_message <= 1'b0;
      fin_valid   <= 1'b0;
    end else begin
      if (pop) begin
        mid_message <= !head.last;
      end
      if (pop && head.last) begin
        fin_valid <= 1'b1;
      end else if (fin_take) begin
        fin_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (pop) begin
      running_crc <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      fin_crc <= crc_next;
    end
  end

endmodule

// ===== hdl/cce_final.sv =====
// Result stage: output reflection, final XOR, masking and the output register.
// Depends on cce_pkg.
module cce_final #(
  parameter int MAX_ORDER = 32,
  parameter int OW        = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cce_pkg::cce_cfg_t    cfg,
  input  logic                 fin_valid,
  input  logic [MAX_ORDER-1:0] fin_crc,
  input  logic [OW-1:0]        ord_n,
  input  logic [MAX_ORDER-1:0] ord_mask,
  output logic                 fin_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_data
);

  logic [MAX_ORDER-1:0] rev_full;
  logic [MAX_ORDER-1:0] refl;
  logic [MAX_ORDER-1:0] result;

  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      rev_full[i] = fin_crc[MAX_ORDER-1-i];
    end
  end

  // full-width reversal, then drop the bits above the order
  assign refl   = rev_full >> (OW'(MAX_ORDER) - ord_n);
  assign result = ((cfg.reflect_out ? refl : fin_crc) ^ MAX_ORDER'(cfg.xor_out)) & ord_mask;

  assign fin_take = fin_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_data <= 32'(result);
    end
  end

endmodule

// ===== hdl/configurable_crc_engine_top.sv =====
// Configurable CRC engine (order 1..MAX_ORDER), top level. Uses cce_pkg, cce_front,
// cce_queue, cce_back, cce_final and assert_macros.svh.
// Throughput: one byte per cycle if not stalled; cce_back's 8-step shift/XOR sets it.
// Last byte path: front register, queue, result register, output register (m_axis).
// Reset (rst, synchronous, active high) restores default config (CRC-32),
// empties the queue and result stages and clears the running CRC; no clearing pass.
`include "assert_macros.svh"

module configurable_crc_engine_top #(
  parameter int MAX_ORDER = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [cce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cce_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // byte stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // last_byte
  // CRC results out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata   // [31:0] crc_result
);

  localparam int OW = $clog2(MAX_ORDER + 1);

  cce_pkg::cce_cfg_t    cfg;
  cce_pkg::cce_item_t   push_item;
  cce_pkg::cce_item_t   head;
  cce_pkg::cce_qstat_t  qstat;
  logic                 push;
  logic                 pop;
  logic                 fin_take;
  logic                 fin_valid;
  logic [MAX_ORDER-1:0] fin_crc;
  logic [OW-1:0]        ord_n;
  logic [MAX_ORDER-1:0] ord_mask;

  // Configuration registers. Writes are meant to come only while nothing is
  // in flight; a write mid-message applies to later bytes, init to the next message.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poly_value  <= cce_pkg::POLY_RESET;
      cfg.crc_order   <= cce_pkg::ORDER_RESET;
      cfg.init_value  <= cce_pkg::INIT_RESET;
      cfg.xor_out     <= cce_pkg::XOR_RESET;
      cfg.reflect_in  <= 1'b1;
      cfg.reflect_out <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cce_pkg::cce_reg_t'(cfg_addr))
        cce_pkg::REG_POLY:        cfg.poly_value  <= cfg_wdata;
        cce_pkg::REG_ORDER:       cfg.crc_order   <= cfg_wdata[cce_pkg::ORDER_W-1:0];
        cce_pkg::REG_INIT:        cfg.init_value  <= cfg_wdata;
        cce_pkg::REG_XOR_OUT:     cfg.xor_out     <= cfg_wdata;
        cce_pkg::REG_REFLECT_IN:  cfg.reflect_in  <= cfg_wdata[0];
        cce_pkg::REG_REFLECT_OUT: cfg.reflect_out <= cfg_wdata[0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // front: takes a transfer, reflects the byte, feeds the queue
  cce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .q_full    (qstat.full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue: front keeps accepting while a result waits downstream
  cce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  // back: running CRC update, one byte per cycle unless the result register is busy
  cce_back #(
    .MAX_ORDER (MAX_ORDER),
    .OW        (OW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .fin_take  (fin_take),
    .fin_valid (fin_valid),
    .fin_crc   (fin_crc),
    .ord_n     (ord_n),
    .ord_mask  (ord_mask)
  );

  // finishing: reflect, xor, mask, output register
  cce_final #(
    .MAX_ORDER (MAX_ORDER),
    .OW        (OW)
  ) u_final (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fin_valid (fin_valid),
    .fin_crc   (fin_crc),
    .ord_n     (ord_n),
    .ord_mask  (ord_mask),
    .fin_take  (fin_take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // queue never pushed when full or popped when empty
  `ASSERT_NEVER(a_push_when_full, clk, rst, push && qstat.full)
  `ASSERT_NEVER(a_pop_when_empty, clk, rst, pop && !qstat.valid)
  // a finished CRC handed over shows up on the output next cycle
  `ASSERT_PROP(a_take_to_out, clk, rst, fin_take |=> m_axis_tvalid)

endmodule

// ===== tb/sv/cce_crc_checker.sv =====
// Checker for the configurable CRC engine: tracks config writes, predicts the CRC of
// each message from the byte transfers and compares the results. Depends on cce_pkg.
module cce_crc_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [cce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cce_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  input  logic                           s_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [31:0]                    m_tdata,
  output int                             errors,
  output int                             pending
);

  logic [31:0]                 poly_q;
  logic [cce_pkg::ORDER_W-1:0] order_q;
  logic [31:0]                 init_q;
  logic [31:0]                 xor_q;
  logic                        rin_q;
  logic                        rout_q;

  logic [31:0] crc_q;
  logic        mid_q;
  logic [31:0] crc_expected[$];

  // reverse the low n bits of v
  function automatic logic [31:0] mirror_bits(input logic [31:0] v, input int unsigned n);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      r[n-1-i] = v[i];
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    int unsigned n;
    logic [32:0] wide_mask;
    logic [31:0] mask, topbit, pm, r, tmp, want;
    logic [7:0]  b;
    logic        fb;
    if (rst) begin
      poly_q  = cce_pkg::POLY_RESET;
      order_q = cce_pkg::ORDER_RESET;
      init_q  = cce_pkg::INIT_RESET;
      xor_q   = cce_pkg::XOR_RESET;
      rin_q   = 1'b1;
      rout_q  = 1'b1;
      crc_q   = '0;
      mid_q   = 1'b0;
      crc_expected.delete();
    end else begin
      // result side first: a result never belongs to a byte of the same edge
      if (m_tvalid && m_tready) begin
        if (crc_expected.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("crc check: unexpected result %h", m_tdata);
        end else begin
          want = crc_expected.pop_front();
          if (m_tdata !== want) begin
            errors++;
            if (errors <= 10)
              $display("crc check: crc_result expected %h actual %h", want, m_tdata);
          end
        end
      end

      if (s_tvalid && s_tready) begin
        n = order_q;
        if (n == 0) n = 1;
        if (n > 32) n = 32;
        wide_mask = (33'd1 << n) - 33'd1;
        mask      = wide_mask[31:0];
        topbit    = 32'd1 << (n - 1);
        pm        = poly_q & mask;
        if (!mid_q) crc_q = init_q & mask;
        r = crc_q & mask;
        if (rin_q) begin
          tmp = mirror_bits({24'd0, s_tdata}, 8);
          b   = tmp[7:0];
        end else begin
          b = s_tdata;
        end
        for (int k = 0; k < 8; k++) begin
          fb = (r & topbit) != 0;
          if (b[7-k]) fb = !fb;
          r = (r << 1) & mask;
          if (fb) r = r ^ pm;
        end
        crc_q = r;
        if (!s_tlast) begin
          mid_q = 1'b1;
        end else begin
          if (rout_q) r = mirror_bits(r, n);
          r = (r ^ xor_q) & mask;
          crc_expected.push_back(r);
          mid_q = 1'b0;
        end
      end

      if (cfg_wr_en) begin
        case (cfg_addr)
          cce_pkg::REG_POLY:        poly_q  = cfg_wdata;
          cce_pkg::REG_ORDER:       order_q = cfg_wdata[cce_pkg::ORDER_W-1:0];
          cce_pkg::REG_INIT:        init_q  = cfg_wdata;
          cce_pkg::REG_XOR_OUT:     xor_q   = cfg_wdata;
          cce_pkg::REG_REFLECT_IN:  rin_q   = cfg_wdata[0];
          cce_pkg::REG_REFLECT_OUT: rout_q  = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending = crc_expected.size();
  end

endmodule

// ===== tb/sv/tb_configurable_crc_engine_top.sv =====
// Testbench top for the configurable CRC engine: drives config writes and byte
// messages, gives the verdict. Depends on cce_pkg, cce_crc_checker and the RTL.
module tb_configurable_crc_engine_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 24;   // well past the pipeline path plus queue
  localparam int ADDR_W       = cce_pkg::CFG_ADDR_W;
  // indexes past the register list
  localparam logic [ADDR_W-1:0] REG_SPARE_LO = ADDR_W'(6);
  localparam logic [ADDR_W-1:0] REG_SPARE_HI = ADDR_W'(7);

  logic                           clk;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [cce_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [cce_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata;
  logic                           s_axis_tlast;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [31:0]                    m_axis_tdata;

  int crc_errors;
  int crc_pending;

  // idle percentages of the two sides, and a long receiver hold-off request
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_req = 0;
  int cycles = 0;

  configurable_crc_engine_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cce_crc_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tlast   (s_axis_tlast),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .errors    (crc_errors),
    .pending   (crc_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_configurable_crc_engine_top: FAIL");
        $finish;
      end
    end
  end

  // Receiver: one decision per falling edge. A hold-off request is latched
  // and counted down here, independent of the sender.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_req != 0) begin
        hold_left     = recv_hold_req;
        recv_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Called at a falling edge, returns at a falling edge with tvalid still high;
  // the next call or wait_idle decides what tvalid does next.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);   // junk on the bus while idle
      s_axis_tlast  <= 1'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // one message of random bytes, last flag on the final one
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  // Sender pause: stop offering, wait for every result, then let any
  // byte without a result leave the pipeline.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (crc_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one register write; the enable drops again before the task returns
  task automatic cfg_write(input logic [cce_pkg::CFG_ADDR_W-1:0] a, input logic [31:0] d);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_crc(input logic [31:0] poly, input logic [31:0] order,
                             input logic [31:0] init, input logic [31:0] xorv,
                             input logic [31:0] rin, input logic [31:0] rout);
    cfg_write(cce_pkg::REG_POLY, poly);
    cfg_write(cce_pkg::REG_ORDER, order);
    cfg_write(cce_pkg::REG_INIT, init);
    cfg_write(cce_pkg::REG_XOR_OUT, xorv);
    cfg_write(cce_pkg::REG_REFLECT_IN, rin);
    cfg_write(cce_pkg::REG_REFLECT_OUT, rout);
  endtask

  // mostly random 32-bit values, with all-zero and all-one extremes mixed in
  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 32'h0000_0000;
    if (sel == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // order: zero, one, 32, saturating values above 32, and the range between
  function automatic logic [31:0] pick_order();
    int unsigned sel;
    logic [31:0] w;
    sel = $urandom_range(0, 9);
    w   = $urandom;
    case (sel)
      0:       w[5:0] = 6'd0;
      1:       w[5:0] = 6'd1;
      2:       w[5:0] = 6'd32;
      3:       w[5:0] = 6'd63;
      4:       w[5:0] = 6'($urandom_range(33, 62));
      default: w[5:0] = 6'($urandom_range(2, 31));
    endcase
    return w;   // upper bits random: the block keeps only six
  endfunction

  // One random phase: fresh config while idle, then well-formed messages.
  // Sometimes a message is left open so the next config lands mid-message.
  task automatic run_phase(input int n_items);
    int sent;
    int len;
    wait_idle();
    program_crc(pick_word(), pick_order(), pick_word(), pick_word(), $urandom, $urandom);
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(REG_SPARE_LO, $urandom);   // indexes past the register list are ignored
      cfg_write(REG_SPARE_HI, $urandom);
    end
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 12);
      else len = $urandom_range(13, 40);
      if (len > n_items - sent) len = n_items - sent;
      send_message(len);
      sent += len;
    end
    if ($urandom_range(0, 2) == 0) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin : stimulus
    logic [7:0] check_str[9];
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----
    send_idle_pct = 15;
    recv_idle_pct = 63;

    // reset config (reflected CRC-32) over the classic check string
    foreach (check_str[i]) send_byte(check_str[i], i == 8);
    // single-byte messages at the byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    // order zero behaves as order one; no reflection
    wait_idle();
    program_crc(32'hFFFF_FFFF, 32'd0, 32'h0000_0001, 32'h0000_0000, 32'd0, 32'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);

    // order 63 saturates to 32; all-ones poly, output reflection only
    wait_idle();
    program_crc(32'hFFFF_FFFF, 32'd63, 32'h0000_0000, 32'h0000_0000, 32'd0, 32'd1);
    send_byte(8'hA5, 1'b1);

    // writes to indexes past the list must change nothing
    wait_idle();
    cfg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_HI, 32'h0000_0000);
    send_byte(8'h5A, 1'b1);

    // CRC-8 style, input reflection; registers change in the middle of a
    // message: poly applies from the next byte, init only from the next message
    wait_idle();
    program_crc(32'h0000_0007, 32'd8, 32'h0000_0000, 32'h0000_0000, 32'd1, 32'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    wait_idle();
    cfg_write(cce_pkg::REG_INIT, 32'h0000_00A5);
    cfg_write(cce_pkg::REG_POLY, 32'h0000_001D);
    send_byte(8'h56, 1'b1);
    send_byte(8'h00, 1'b1);

    // ---- random part, three idling modes ----
    for (int ph = 0; ph < 4; ph++) run_phase(65);

    send_idle_pct = 63;
    recv_idle_pct = 15;
    for (int ph = 0; ph < 4; ph++) run_phase(65);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int ph = 0; ph < 4; ph++) run_phase(65);

    // back-pressure: receiver holds off long while short messages keep coming,
    // so results pile up and the input stalls
    wait_idle();
    recv_hold_req = 250;
    for (int i = 0; i < 20; i++) send_message($urandom_range(1, 5));
    // sender pause until every result is back
    wait_idle();
    send_message(6);

    // ---- end of run ----
    wait_idle();
    if (crc_errors == 0 && crc_pending == 0) begin
      $display("tb_configurable_crc_engine_top: PASS");
    end else begin
      $display("tb_configurable_crc_engine_top: FAIL");
    end
    $finish;
  end

endmodule
